// ===== sv/salc_pkg.sv =====
`timescale 1ns / 1ps

package salc_pkg;

  // Default sizing
  localparam int DEF_MAX_SETS   = 64;
  localparam int DEF_MAX_WAYS   = 8;
  localparam int DEF_ADDR_WIDTH = 64;

  // Field widths
  localparam int ADDR_FIELD_W = 64;
  localparam int TOTAL_W      = 32;
  localparam int STAMP_W      = 32;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 6;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

  // Access outcome codes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  typedef struct packed {
    logic                    kind;
    logic [ADDR_FIELD_W-1:0] address;
  } access_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic               last;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] eviction_total;
  } result_t;

  typedef struct packed {
    logic [2:0] set_index_bits;
    logic [3:0] ways_in_use;
    logic [5:0] block_offset_bits;
  } cfg_t;

  // Width of an index into n entries, at least one bit
  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== sv/salc_line_mem.sv =====
`timescale 1ns / 1ps

module salc_line_mem import salc_pkg::*; #(
  parameter int DEPTH = DEF_MAX_SETS * DEF_MAX_WAYS,
  parameter int AW    = 9,
  parameter int ROW_W = 1 + STAMP_W + DEF_ADDR_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ROW_W-1:0] rd_row,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_row,
  output logic             init_done
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic             clearing;
  logic [AW-1:0]    clr_addr;

  // Post-reset sweep: every line goes invalid with a zero stamp
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  assign init_done = ~clearing;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/salc_seq.sv =====
`timescale 1ns / 1ps

module salc_seq import salc_pkg::*; #(
  parameter int MAX_SETS   = DEF_MAX_SETS,
  parameter int MAX_WAYS   = DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  cfg_t                                       cfg,
  input  logic                                       access_valid,
  output logic                                       access_ready,
  input  access_t                                    access,
  output logic                                       result_valid,
  input  logic                                       result_ready,
  output result_t                                    result,
  output logic                                       rd_en,
  output logic [idx_width(MAX_SETS)+idx_width(MAX_WAYS)-1:0] rd_addr,
  input  logic [STAMP_W+ADDR_WIDTH:0]                rd_row,
  output logic                                       wr_en,
  output logic [idx_width(MAX_SETS)+idx_width(MAX_WAYS)-1:0] wr_addr,
  output logic [STAMP_W+ADDR_WIDTH:0]                wr_row,
  input  logic                                       init_done
);

  localparam int SET_W    = idx_width(MAX_SETS);
  localparam int WAY_W    = idx_width(MAX_WAYS);
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int LOG_SETS = $clog2(MAX_SETS + 1) - 1;
  localparam int TAG_W    = ADDR_WIDTH;
  localparam int ROW_W    = 1 + STAMP_W + TAG_W;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_SCAN   = 6'b001000,
    S_UPDATE = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state, state_next;

  // Item and lookup registers
  logic                  kind_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [SET_W-1:0]      set_q;
  logic [TAG_W-1:0]      tag_q;
  logic                  second;

  // Scan registers
  logic [WCNT_W-1:0]  rd_way;
  logic               pend;
  logic [WAY_W-1:0]   chk_way;
  logic               hit_found;
  logic [WAY_W-1:0]   hit_way;
  logic               inv_found;
  logic [WAY_W-1:0]   inv_way;
  logic [WAY_W-1:0]   vic_way;
  logic [STAMP_W-1:0] vic_stamp;
  logic [WAY_W-1:0]   tgt_way;

  // Clock and totals
  logic [STAMP_W-1:0] clock_q;
  logic [TOTAL_W-1:0] hit_cnt, miss_cnt, evict_cnt;
  logic [TOTAL_W-1:0] hit_next, miss_next, evict_next;
  logic [STAMP_W-1:0] clock_new;

  result_t res_q;

  // Effective geometry
  logic [2:0]        sb_eff;
  logic [WCNT_W-1:0] ways_eff;
  logic [WCNT_W-1:0] ways_last;

  // Address split
  logic [ADDR_WIDTH-1:0] blk;
  logic [ADDR_WIDTH-1:0] tag_val;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_val;

  // Row fields from memory
  logic               row_valid;
  logic [STAMP_W-1:0] row_stamp;
  logic [TAG_W-1:0]   row_tag;
  logic               scan_done;

  // Way choice for the write-back
  logic [WAY_W-1:0] sel_way;
  logic [1:0]       sel_outcome;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + TOTAL_W'(1);
  endfunction

  // Clamp set bits and way count to the built geometry
  always_comb begin
    sb_eff = (32'(cfg.set_index_bits) > LOG_SETS) ? 3'(LOG_SETS) : cfg.set_index_bits;
    if (cfg.ways_in_use == 4'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(cfg.ways_in_use) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(cfg.ways_in_use);
    end
    ways_last = ways_eff - WCNT_W'(1);
  end

  // Block, set and tag by shifts
  always_comb begin
    blk      = addr_q >> cfg.block_offset_bits;
    tag_val  = addr_q >> ({1'b0, cfg.block_offset_bits} + 7'(sb_eff));
    set_mask = ~({SET_W{1'b1}} << sb_eff);
    set_val  = blk[SET_W-1:0] & set_mask;
  end

  assign row_valid = rd_row[ROW_W-1];
  assign row_stamp = rd_row[ROW_W-2 -: STAMP_W];
  assign row_tag   = rd_row[TAG_W-1:0];
  assign scan_done = pend && (WCNT_W'(chk_way) == ways_last);

  // The second pass of a modify reuses its way; else hit first, then the first empty way, then the oldest stamp
  always_comb begin
    if (second) begin
      sel_way     = tgt_way;
      sel_outcome = OUT_HIT;
    end else if (hit_found) begin
      sel_way     = hit_way;
      sel_outcome = OUT_HIT;
    end else if (inv_found) begin
      sel_way     = inv_way;
      sel_outcome = OUT_FILL;
    end else begin
      sel_way     = vic_way;
      sel_outcome = OUT_EVICT;
    end
  end

  // Totals after this access
  always_comb begin
    clock_new  = sat_inc(clock_q);
    hit_next   = hit_cnt;
    miss_next  = miss_cnt;
    evict_next = evict_cnt;
    if (sel_outcome == OUT_HIT) begin
      hit_next = sat_inc(hit_cnt);
    end else begin
      miss_next = sat_inc(miss_cnt);
      if (sel_outcome == OUT_EVICT) begin
        evict_next = sat_inc(evict_cnt);
      end
    end
  end

  // Line memory ports
  assign rd_en   = (state == S_SCAN) && (rd_way < ways_eff);
  assign rd_addr = {set_q, rd_way[WAY_W-1:0]};
  assign wr_en   = (state == S_UPDATE);
  assign wr_addr = {set_q, sel_way};
  assign wr_row  = {1'b1, clock_new, tag_q};

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (init_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (access_valid) state_next = S_DECODE;
      end
      S_DECODE: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_done) state_next = S_UPDATE;
      end
      S_UPDATE: state_next = S_EMIT;
      S_EMIT: begin
        if (result_ready) begin
          state_next = (kind_q && !second) ? S_UPDATE : S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Control state and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      second    <= 1'b0;
      pend      <= 1'b0;
      clock_q   <= '0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
    end else begin
      state <= state_next;
      pend  <= rd_en;
      if (state == S_IDLE) begin
        second <= 1'b0;
      end
      if (state == S_EMIT && result_ready && kind_q && !second) begin
        second <= 1'b1;
      end
      if (state == S_UPDATE) begin
        clock_q   <= clock_new;
        hit_cnt   <= hit_next;
        miss_cnt  <= miss_next;
        evict_cnt <= evict_next;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && access_valid) begin
      kind_q <= access.kind;
      addr_q <= access.address[ADDR_WIDTH-1:0];
    end
    if (state == S_DECODE) begin
      set_q     <= set_val;
      tag_q     <= tag_val;
      rd_way    <= '0;
      hit_found <= 1'b0;
      inv_found <= 1'b0;
    end
    if (rd_en) begin
      rd_way  <= rd_way + WCNT_W'(1);
      chk_way <= rd_way[WAY_W-1:0];
    end
    // Compare one way per cycle
    if (state == S_SCAN && pend) begin
      if (!hit_found && row_valid && row_tag == tag_q) begin
        hit_found <= 1'b1;
        hit_way   <= chk_way;
      end
      if (!inv_found && !row_valid) begin
        inv_found <= 1'b1;
        inv_way   <= chk_way;
      end
      if (chk_way == '0 || row_stamp < vic_stamp) begin
        vic_way   <= chk_way;
        vic_stamp <= row_stamp;
      end
    end
    if (state == S_UPDATE) begin
      tgt_way              <= sel_way;
      res_q.outcome        <= sel_outcome;
      res_q.last           <= !kind_q || second;
      res_q.hit_total      <= hit_next;
      res_q.miss_total     <= miss_next;
      res_q.eviction_total <= evict_next;
    end
  end

  assign access_ready = (state == S_IDLE);
  assign result_valid = (state == S_EMIT);
  assign result       = res_q;

endmodule

// ===== sv/set_assoc_lru_cache_sim.sv =====
`timescale 1ns / 1ps

// Tag-only set-associative cache model with LRU replacement. An access beat
// carries a kind (0 load/store, 1 modify) and a byte address; a load/store
// returns one result beat, a modify two (the second always hits), each with
// the outcome and saturating hit, miss and eviction totals. Lines sit in one
// single-port-read memory, and the sequencer reads the ways of the set one
// per cycle through a shared tag/stamp compare; a new access is taken only
// once the last result beat of the one before has been accepted. After reset
// the line memory's MAX_SETS * 2**max(1, ceil(log2(MAX_WAYS))) lines (512 at
// the default size) are swept clear before the first access is taken;
// configuration writes are taken at any time but belong only between items.
module set_assoc_lru_cache_sim import salc_pkg::*; #(
  parameter int MAX_SETS   = DEF_MAX_SETS,
  parameter int MAX_WAYS   = DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   access_valid,
  output logic                   access_ready,
  input  access_t                access,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SET_W = idx_width(MAX_SETS);
  localparam int WAY_W = idx_width(MAX_WAYS);
  localparam int AW    = SET_W + WAY_W;
  localparam int DEPTH = MAX_SETS * (2 ** WAY_W);
  localparam int ROW_W = 1 + STAMP_W + ADDR_WIDTH;

  cfg_t             cfg;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [ROW_W-1:0] rd_row;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [ROW_W-1:0] wr_row;
  logic             init_done;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_index_bits    <= 3'd0;
      cfg.ways_in_use       <= 4'd1;
      cfg.block_offset_bits <= 6'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SET_INDEX_BITS:    cfg.set_index_bits    <= cfg_data[2:0];
        CFG_WAYS_IN_USE:       cfg.ways_in_use       <= cfg_data[3:0];
        CFG_BLOCK_OFFSET_BITS: cfg.block_offset_bits <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  salc_seq #(
    .MAX_SETS   (MAX_SETS),
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .access       (access),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_row       (rd_row),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_row       (wr_row),
    .init_done    (init_done)
  );

  salc_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .ROW_W (ROW_W)
  ) u_line_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_row    (rd_row),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_row    (wr_row),
    .init_done (init_done)
  );

endmodule
